@@ sv/hsec_pkg.sv @@
// hsec_pkg: widths, stage and result types, and codeword layout helpers
// for the hamming single error correct core; depends on nothing
package hsec_pkg;

   localparam int CW_W    = 62;
   localparam int DATA_W  = 56;
   localparam int SYN_W   = 6;
   localparam int BYTES_W = 3;
   localparam int LEN_W   = 6;
   localparam int POS_W   = 6;

   // input stage register contents
   typedef struct packed {
      logic [CW_W-1:0]    cw;
      logic [LEN_W-1:0]   len;
      logic [BYTES_W-1:0] bytes;
   } stage_type;

   // one decoded result beat
   typedef struct packed {
      logic [DATA_W-1:0] data_out;
      logic [SYN_W-1:0]  syndrome;
      logic              corrected;
      logic              uncorrectable;
   } result_type;

   // codeword length for 1..7 data bytes
   function automatic logic [LEN_W-1:0] code_len(input logic [BYTES_W-1:0] bytes);
      logic [LEN_W-1:0] len;
      case (bytes)
         3'd1:    len = 6'd12;
         3'd2:    len = 6'd21;
         3'd3:    len = 6'd29;
         3'd4:    len = 6'd38;
         3'd5:    len = 6'd46;
         3'd6:    len = 6'd54;
         3'd7:    len = 6'd62;
         default: len = 6'd12;
      endcase
      return len;
   endfunction

   // positions (counting from 1) covered by check bit k
   function automatic logic [CW_W-1:0] cover_mask(input int k);
      logic [CW_W-1:0] mask;
      mask = '0;
      for (int p = 1; p <= CW_W; p++) begin
         if (((p >> k) & 1) == 1) mask[p-1] = 1'b1;
      end
      return mask;
   endfunction

   // field bit of the i-th data position, first data position is i = 0
   function automatic logic [POS_W-1:0] data_pos(input int i);
      int cnt;
      int pos;
      cnt = 0;
      pos = 0;
      for (int p = 1; p <= CW_W; p++) begin
         if ((p & (p - 1)) != 0) begin
            if (cnt == i) pos = p - 1;
            cnt++;
         end
      end
      return POS_W'(pos);
   endfunction

endpackage

@@ sv/hsec_req_if.sv @@
// hsec_req_if: codeword channel, valid/ready with the received codeword
// depends on hsec_pkg for the field width
interface hsec_req_if;
   logic                       valid;
   logic                       ready;
   logic [hsec_pkg::CW_W-1:0]  codeword;

   modport source (output valid, output codeword, input ready);
   modport sink   (input valid, input codeword, output ready);
endinterface

@@ sv/hsec_rsp_if.sv @@
// hsec_rsp_if: result channel, valid/ready with data and error status
// depends on hsec_pkg for the field widths
interface hsec_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [hsec_pkg::DATA_W-1:0]  data_out;
   logic [hsec_pkg::SYN_W-1:0]   syndrome;
   logic                         corrected;
   logic                         uncorrectable;

   modport source (output valid, output data_out, output syndrome,
                   output corrected, output uncorrectable, input ready);
   modport sink   (input valid, input data_out, input syndrome,
                   input corrected, input uncorrectable, output ready);
endinterface

@@ sv/hamming_single_error_correct_core.sv @@
// hamming_single_error_correct_core: top level, csr register, input and
// result registers; depends on hsec_pkg, hsec_req_if, hsec_rsp_if,
// hsec_syndrome and hsec_extract

// Decodes one Hamming codeword per beat: check bits sit at the power-of-two
// positions, position p is codeword bit p-1, and the length (12, 21, 29, 38,
// 46, 54 or 62) follows from the data byte count in the csr (zero reads as
// one, values above MAX_DATA_BYTES saturate). A syndrome within the codeword
// flips that bit and sets corrected; a syndrome beyond it sets uncorrectable
// and leaves the data untouched. The path from request beat to result beat
// is one input register, then parity trees, flip and packing feeding the
// result register. Throughput is one codeword per cycle while rsp ready
// holds; a new request enters an empty input register while a finished
// result still waits. Write the csr only while no beat is in flight.
module hamming_single_error_correct_core #(
   parameter int MAX_DATA_BYTES = 7
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [hsec_pkg::BYTES_W-1:0]   csr_wr_data,
   hsec_req_if.sink                       req_chan,
   hsec_rsp_if.source                     rsp_chan
);

   localparam logic [hsec_pkg::BYTES_W-1:0] MAX_BYTES = hsec_pkg::BYTES_W'(MAX_DATA_BYTES);

   // csr
   logic [hsec_pkg::BYTES_W-1:0] data_bytes_ff;
   logic [hsec_pkg::BYTES_W-1:0] eff_bytes;

   // pipeline
   hsec_pkg::stage_type   stage_ff, stage_in;
   logic                  stage_valid_ff;
   hsec_pkg::result_type  result_ff, result_in;
   logic                  result_valid_ff;
   logic                  result_adv;
   logic                  stage_adv;
   logic [hsec_pkg::SYN_W-1:0] syndrome;

   // config register, reset to one data byte
   always_ff @(posedge clock) begin
      if (reset) begin
         data_bytes_ff <= 3'd1;
      end else if (csr_wr_en) begin
         data_bytes_ff <= csr_wr_data;
      end
   end

   // clamp to 1..MAX_DATA_BYTES
   always_comb begin
      eff_bytes = data_bytes_ff;
      if (eff_bytes == '0) eff_bytes = 3'd1;
      if (eff_bytes > MAX_BYTES) eff_bytes = MAX_BYTES;
   end

   // result register moves when empty or taken; stage moves when result does
   assign result_adv     = !result_valid_ff || rsp_chan.ready;
   assign stage_adv      = !stage_valid_ff || result_adv;
   assign req_chan.ready = stage_adv;

   // mask off bits beyond the codeword on the way in
   always_comb begin
      stage_in.len   = hsec_pkg::code_len(eff_bytes);
      stage_in.bytes = eff_bytes;
      stage_in.cw    = req_chan.codeword &
                       ((hsec_pkg::CW_W'(1) << stage_in.len) - hsec_pkg::CW_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (stage_adv) begin
         stage_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_adv && req_chan.valid) begin
         stage_ff <= stage_in;
      end
   end

   hsec_syndrome u_syndrome (
      .cw       (stage_ff.cw),
      .syndrome (syndrome)
   );

   hsec_extract u_extract (
      .stage    (stage_ff),
      .syndrome (syndrome),
      .result   (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         result_valid_ff <= 1'b0;
      end else if (result_adv) begin
         result_valid_ff <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (result_adv && stage_valid_ff) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid         = result_valid_ff;
   assign rsp_chan.data_out      = result_ff.data_out;
   assign rsp_chan.syndrome      = result_ff.syndrome;
   assign rsp_chan.corrected     = result_ff.corrected;
   assign rsp_chan.uncorrectable = result_ff.uncorrectable;

   // a flip and an uncorrectable flag never come together
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.corrected && rsp_chan.uncorrectable))
      else $error("corrected and uncorrectable both set");

   // clean syndrome means no status flags
   a_zero_syndrome_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.syndrome == '0)) |->
         (!rsp_chan.corrected && !rsp_chan.uncorrectable))
      else $error("status flag with zero syndrome");

   // no output stall means the input side is open
   a_no_stall_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.ready |-> req_chan.ready)
      else $error("request side blocked without result backpressure");

   // an accepted beat reaches the result register via the input register when unstalled
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && rsp_chan.ready) ##1 rsp_chan.ready
         |=> rsp_chan.valid)
      else $error("accepted beat did not reach the result register");

endmodule

@@ sv/hsec_syndrome.sv @@
// hsec_syndrome: parity trees over the masked codeword, one per check bit
// depends on hsec_pkg
module hsec_syndrome (
   input  logic [hsec_pkg::CW_W-1:0]  cw,
   output logic [hsec_pkg::SYN_W-1:0] syndrome
);

   // positions beyond the codeword are zero, so full-width masks suffice
   always_comb begin
      for (int k = 0; k < hsec_pkg::SYN_W; k++) begin
         syndrome[k] = ^(cw & hsec_pkg::cover_mask(k));
      end
   end

endmodule

@@ sv/hsec_extract.sv @@
// hsec_extract: single bit flip, data bit packing and right alignment
// depends on hsec_pkg
module hsec_extract (
   input  hsec_pkg::stage_type         stage,
   input  logic [hsec_pkg::SYN_W-1:0]  syndrome,
   output hsec_pkg::result_type        result
);

   logic                        in_range;
   logic                        do_flip;
   logic [hsec_pkg::CW_W-1:0]   flip_vec;
   logic [hsec_pkg::CW_W-1:0]   cw_fix;
   logic [hsec_pkg::DATA_W-1:0] packed_all;
   logic [hsec_pkg::BYTES_W-1:0] pad_bytes;
   logic [hsec_pkg::POS_W-1:0]  shift_amt;

   assign in_range = (syndrome <= stage.len);
   assign do_flip  = (syndrome != '0) && in_range;
   assign flip_vec = do_flip ? (hsec_pkg::CW_W'(1) << (syndrome - 6'd1)) : '0;
   assign cw_fix   = stage.cw ^ flip_vec;

   // first data position lands in the msb
   for (genvar i = 0; i < hsec_pkg::DATA_W; i++) begin : g_pack
      assign packed_all[hsec_pkg::DATA_W-1-i] = cw_fix[hsec_pkg::data_pos(i)];
   end

   // unused data positions are zero and fall off the bottom
   assign pad_bytes = 3'd7 - stage.bytes;
   assign shift_amt = {pad_bytes, 3'b000};

   always_comb begin
      result.data_out      = packed_all >> shift_amt;
      result.syndrome      = syndrome;
      result.corrected     = do_flip;
      result.uncorrectable = (syndrome != '0) && !in_range;
   end

endmodule

@@ sim/testbench.sv @@
// testbench for hamming_single_error_correct_core: random and directed
// codewords, in-order result checking; depends on hsec_pkg, hsec_req_if,
// hsec_rsp_if and the core itself

localparam int ROW_BYTES_MAX = 7;

// holds the expected decodes of accepted codewords and checks result beats
class sec_decode_tracker;
   hsec_pkg::result_type pending_decodes[$];
   logic [hsec_pkg::BYTES_W-1:0] row_bytes;
   int mismatches;

   function new();
      row_bytes  = 3'd1;
      mismatches = 0;
   endfunction

   function void set_bytes(logic [hsec_pkg::BYTES_W-1:0] value);
      row_bytes = value;
   endfunction

   // codeword length for the current byte count
   function int row_length();
      int b;
      int placed;
      int p;
      b = row_bytes;
      if (b < 1) b = 1;
      if (b > ROW_BYTES_MAX) b = ROW_BYTES_MAX;
      placed = 0;
      p = 0;
      while (placed < 8 * b) begin
         p++;
         if ((p & (p - 1)) != 0) placed++;
      end
      return p;
   endfunction

   function hsec_pkg::result_type decode_codeword(logic [hsec_pkg::CW_W-1:0] received);
      int n;
      int syn;
      bit par;
      logic [63:0] word;
      logic [63:0] data_bits;
      hsec_pkg::result_type res;
      n = row_length();
      word = {2'b00, received} & ((64'd1 << n) - 64'd1);
      syn = 0;
      for (int k = 0; (1 << k) <= n; k++) begin
         par = 1'b0;
         for (int p = 1; p <= n; p++) begin
            if (((p >> k) & 1) == 1) par ^= word[p-1];
         end
         if (par) syn += (1 << k);
      end
      res = '0;
      res.syndrome = syn[hsec_pkg::SYN_W-1:0];
      if (syn != 0) begin
         if (syn <= n) begin
            word[syn-1] = ~word[syn-1];
            res.corrected = 1'b1;
         end else begin
            res.uncorrectable = 1'b1;
         end
      end
      data_bits = '0;
      for (int p = 1; p <= n; p++) begin
         if ((p & (p - 1)) != 0) data_bits = {data_bits[62:0], word[p-1]};
      end
      res.data_out = data_bits[hsec_pkg::DATA_W-1:0];
      return res;
   endfunction

   function void note_codeword(logic [hsec_pkg::CW_W-1:0] cw);
      pending_decodes = {pending_decodes, decode_codeword(cw)};
   endfunction

   function void check_decoded(logic [hsec_pkg::DATA_W-1:0] data_out,
                               logic [hsec_pkg::SYN_W-1:0] syndrome,
                               logic corrected, logic uncorrectable);
      hsec_pkg::result_type want;
      if (pending_decodes.size() == 0) begin
         $display("%0t: result beat with no codeword outstanding, data %h syndrome %h",
                  $time, data_out, syndrome);
         mismatches++;
         return;
      end
      want = pending_decodes.pop_front();
      if (data_out !== want.data_out) begin
         $display("%0t: data_out expected %h actual %h", $time, want.data_out, data_out);
         mismatches++;
      end
      if (syndrome !== want.syndrome) begin
         $display("%0t: syndrome expected %h actual %h", $time, want.syndrome, syndrome);
         mismatches++;
      end
      if (corrected !== want.corrected) begin
         $display("%0t: corrected expected %b actual %b", $time, want.corrected, corrected);
         mismatches++;
      end
      if (uncorrectable !== want.uncorrectable) begin
         $display("%0t: uncorrectable expected %b actual %b",
                  $time, want.uncorrectable, uncorrectable);
         mismatches++;
      end
   endfunction

   function int outstanding();
      return pending_decodes.size();
   endfunction
endclass

module testbench;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [hsec_pkg::BYTES_W-1:0] csr_wr_data;

   hsec_req_if req_chan();
   hsec_rsp_if rsp_chan();

   sec_decode_tracker tracker = new();

   // when set, neither side inserts idle cycles
   bit no_idle;

   hamming_single_error_correct_core #(
      .MAX_DATA_BYTES(ROW_BYTES_MAX)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // mostly back to back or short gaps, now and then a long one
   function automatic int idle_len();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [hsec_pkg::CW_W-1:0] flip_at(logic [hsec_pkg::CW_W-1:0] cw,
                                                         int pos);
      return cw ^ (62'd1 << (pos - 1));
   endfunction

   function automatic logic [hsec_pkg::CW_W-1:0] random_word();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[hsec_pkg::CW_W-1:0];
   endfunction

   // valid codeword for the current length; first data bit lands at position 3
   function automatic logic [hsec_pkg::CW_W-1:0] clean_row(
      logic [hsec_pkg::DATA_W-1:0] payload);
      int n;
      int ndata;
      int i;
      logic [hsec_pkg::CW_W-1:0] cw;
      logic [hsec_pkg::SYN_W-1:0] syn;
      n = tracker.row_length();
      ndata = 0;
      for (int p = 1; p <= n; p++) begin
         if ((p & (p - 1)) != 0) ndata++;
      end
      cw = '0;
      i = 0;
      for (int p = 1; p <= n; p++) begin
         if ((p & (p - 1)) != 0) begin
            cw[p-1] = payload[ndata-1-i];
            i++;
         end
      end
      // with all check bits zero the syndrome is exactly the check bits needed
      syn = tracker.decode_codeword(cw).syndrome;
      for (int k = 0; (1 << k) <= n; k++) cw[(1 << k) - 1] = syn[k];
      return cw;
   endfunction

   // present one codeword beat and hold it until the core takes it
   task automatic send_codeword(logic [hsec_pkg::CW_W-1:0] cw);
      int gap;
      gap = idle_len();
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid    <= 1'b1;
      req_chan.codeword <= cw;
      do @(posedge clock); while (!req_chan.ready);
      tracker.note_codeword(cw);
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain_results();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      // two stage pipeline, leave a little slack
      repeat (4) @(posedge clock);
   endtask

   task automatic program_row_bytes(logic [hsec_pkg::BYTES_W-1:0] value);
      drain_results();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      tracker.set_bytes(value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // well-formed rows with random data and zero, one or two flipped bits,
   // plus some pure noise; junk above the row length half the time
   task automatic send_random_rows(int count);
      int kind;
      int n;
      int p1;
      int p2;
      logic [hsec_pkg::CW_W-1:0] cw;
      logic [63:0] payload;
      logic [63:0] row_mask;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(0, 99);
         n = tracker.row_length();
         payload = {$urandom, $urandom};
         cw = clean_row(payload[hsec_pkg::DATA_W-1:0]);
         if (kind < 35) begin
            cw = flip_at(cw, $urandom_range(1, n));
         end else if (kind < 50) begin
            p1 = $urandom_range(1, n);
            p2 = $urandom_range(1, n - 1);
            if (p2 >= p1) p2++;
            cw = flip_at(flip_at(cw, p1), p2);
         end else if (kind >= 80) begin
            cw = random_word();
         end
         if ($urandom_range(0, 1) == 1) begin
            row_mask = (64'd1 << n) - 64'd1;
            cw = cw | (random_word() & ~row_mask[hsec_pkg::CW_W-1:0]);
         end
         send_codeword(cw);
      end
   endtask

   // result side: ready drops for random stretches, with bursts of ready between
   initial begin
      int gap;
      int burst;
      rsp_chan.ready = 1'b0;
      @(negedge reset);
      forever begin
         gap = idle_len();
         repeat (gap) begin
            @(negedge clock);
            rsp_chan.ready <= 1'b0;
         end
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            @(negedge clock);
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // every accepted result beat goes to the tracker
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         tracker.check_decoded(rsp_chan.data_out, rsp_chan.syndrome,
                               rsp_chan.corrected, rsp_chan.uncorrectable);
      end
   end

   // stimulus: directed rows at the short and long extremes, then a sweep of
   // byte counts (zero among them) with random rows in each
   initial begin
      logic [hsec_pkg::BYTES_W-1:0] row_plan[9];
      row_plan = '{3'd1, 3'd7, 3'd0, 3'd3, 3'd5, 3'd2, 3'd4, 3'd6, 3'd7};
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      req_chan.valid    = 1'b0;
      req_chan.codeword = '0;
      no_idle           = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < 9; ph++) begin
         program_row_bytes(row_plan[ph]);
         // every third phase runs with no idle cycles on either side
         no_idle = (ph % 3 == 2);
         if (ph == 0) begin
            // twelve bit row, syndromes 13..15 fall outside it
            send_codeword('0);
            send_codeword('1);
            send_codeword(clean_row(56'hA5));
            send_codeword(flip_at(clean_row(56'h80), 1));
            send_codeword(flip_at(clean_row(56'h80), 2));
            send_codeword(flip_at(clean_row(56'h01), 12));
            send_codeword(flip_at(flip_at(clean_row(56'h3C), 5), 8));
            send_codeword(flip_at(flip_at(clean_row(56'h00), 7), 8));
            // only bits beyond the row set, decodes as all zero
            send_codeword({50'h3_FFFF_FFFF_FFFF, 12'h000});
         end else if (ph == 1) begin
            // full 62 bit row, syndrome 63 is the only one outside it
            send_codeword(clean_row('1));
            send_codeword(flip_at(clean_row('1), 62));
            send_codeword(flip_at(flip_at(clean_row(56'h80_0000_0000_0000), 31), 32));
            send_codeword(flip_at(clean_row('0), 1));
            // double error aliasing onto the last position
            send_codeword(flip_at(flip_at(clean_row(56'h12_3456_789A_BCDE), 61), 3));
            send_codeword('1);
         end else if (ph == 2) begin
            // zero byte count behaves as one byte
            send_codeword(flip_at(clean_row(56'hC3), 10));
            send_codeword('1);
         end
         send_random_rows(150);
      end

      no_idle = 1'b0;
      drain_results();
      repeat (6) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #10000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
